>>> sv/spq_pkg.sv
// Package with shared constants, codes and control types of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int SPQ_DEPTH         = 16;
  localparam int SPQ_PRIORITY_BITS = 8;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int PRI_IN_W = 8;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming operation
    logic execute;  // update the cell chain and load the result register
  } spq_cmd_t;

endpackage

>>> sv/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
`timescale 1ns / 1ps

module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output spq_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready   = (state_r == ST_IDLE);
  assign out_tvalid  = out_valid_r;
  assign cmd.capture = in_tvalid && in_tready;
  // The result register may be reloaded once its old content is gone or leaves now.
  assign cmd.execute = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.execute) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("executed operation did not present a result");

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC) && !in_tready)
    else $error("captured operation did not enter execution");

  a_wait_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && out_valid_r && !out_tready |=> (state_r == ST_EXEC))
    else $error("operation executed over an untaken result");
`endif

endmodule

>>> sv/spq_dpath.sv
// Datapath of the sorted priority queue: operation latch, sorted cell chain, result register.
`timescale 1ns / 1ps

module spq_dpath
  import spq_pkg::*;
#(
  parameter int DEPTH         = SPQ_DEPTH,
  parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spq_cmd_t              cmd,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [VALUE_W-1:0]    in_item_value,
  input  logic [PRI_IN_W-1:0]   in_item_priority,
  output logic [VALUE_W-1:0]    out_result_value,
  output logic [STAT_W-1:0]     out_status,
  output logic [OCC_W-1:0]      out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KIND_W-1:0]        kind_r;
  logic [VALUE_W-1:0]       val_r;
  logic [PRIORITY_BITS-1:0] pri_r;

  logic [VALUE_W-1:0]       cell_val_r [DEPTH];
  logic [VALUE_W-1:0]       cell_val_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri_r [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri_nxt [DEPTH];
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic [STAT_W-1:0]  res_st_r, res_st_nxt;
  logic [OCC_W-1:0]   res_occ_r, res_occ_nxt;

  logic [DEPTH-1:0] at_or_after;  // cell lies at or behind the insertion point
  logic [DEPTH-1:0] prev_after;
  logic             full, empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Every cell compares its priority with the new one at once. Held cells are
  // sorted, so the flags rise once and stay high; empty cells count as behind.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      at_or_after[i] = (count_r <= CNT_W'(i)) || (cell_pri_r[i] >= pri_r);
    end
    prev_after[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) begin
      prev_after[i] = at_or_after[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_val_nxt[i] = cell_val_r[i];
      cell_pri_nxt[i] = cell_pri_r[i];
    end
    count_nxt   = count_r;
    res_val_nxt = '0;
    res_st_nxt  = ST_OK;
    case (kind_r)
      KIND_PUSH: begin
        res_val_nxt = val_r;
        if (full) begin
          res_st_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (at_or_after[i] && !prev_after[i]) begin
              cell_val_nxt[i] = val_r;
              cell_pri_nxt[i] = pri_r;
            end
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (at_or_after[i] && prev_after[i]) begin
              cell_val_nxt[i] = cell_val_r[i-1];
              cell_pri_nxt[i] = cell_pri_r[i-1];
            end
          end
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (empty) begin
          res_st_nxt = ST_EMPTY;
        end else begin
          res_val_nxt = cell_val_r[0];
          if (kind_r == KIND_POP) begin
            count_nxt = count_r - CNT_W'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
              cell_val_nxt[i] = cell_val_r[i+1];
              cell_pri_nxt[i] = cell_pri_r[i+1];
            end
          end
        end
      end
      default: begin
        res_val_nxt = '0;
      end
    endcase
    res_occ_nxt = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      val_r  <= in_item_value;
      pri_r  <= PRIORITY_BITS'(in_item_priority);
    end
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_val_r[i] <= cell_val_nxt[i];
        cell_pri_r[i] <= cell_pri_nxt[i];
      end
      res_val_r <= res_val_nxt;
      res_st_r  <= res_st_nxt;
      res_occ_r <= res_occ_nxt;
    end
  end

  assign out_result_value = res_val_r;
  assign out_status       = res_st_r;
  assign out_occupancy    = res_occ_r;

endmodule

>>> sv/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
// The result is offered once its operation executes: the transfer edge
// latches the operation, and in the execute state every cell of the chain
// compares and shifts in parallel while the result register loads at its end.
// The latch-then-execute sequence of the controller takes a new operation only
// after the last has executed; a stalled result lets the next operation
// transfer but holds its execution, and input ready stays low until it executes.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH         = SPQ_DEPTH,
  parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] item_value, [39:32] item_priority
  input  logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [31:0] result_value, [33:32] status,
                                            // [38:34] occupancy, [39] zero
);

  spq_cmd_t cmd;

  logic [VALUE_W-1:0] res_val;
  logic [STAT_W-1:0]  res_st;
  logic [OCC_W-1:0]   res_occ;

  // The controller decides when an operation is latched and when it executes;
  // it only executes once the result register is free or being emptied.
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The datapath keeps the entries sorted by ascending priority in a chain of
  // cells; a push inserts ahead of the first entry with equal or larger
  // priority, and a pop shifts the whole chain one place toward the head.
  spq_dpath #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_tuser),
    .in_item_value    (in_tdata[VALUE_W-1:0]),
    .in_item_priority (in_tdata[VALUE_W +: PRI_IN_W]),
    .out_result_value (res_val),
    .out_status       (res_st),
    .out_occupancy    (res_occ)
  );

  // Pack the result fields from the lowest bit up, padding the top bit.
  assign out_tdata = {1'b0, res_occ, res_st, res_val};

endmodule
